### rtl/core/ps2t_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2t_pkg
// Shared types, scan code constants and the set 2 to ASCII key maps.
// ----------------------------------------------------------------------------
package ps2t_pkg;

  // Special scan codes (set 2)
  localparam logic [7:0] CODE_BREAK  = 8'hF0;
  localparam logic [7:0] CODE_LSHIFT = 8'h12;
  localparam logic [7:0] CODE_RSHIFT = 8'h59;
  localparam logic [7:0] CODE_BKSP   = 8'h66;

  // Fill character of an empty line entry
  localparam logic [7:0] BLANK = 8'h20;

  // What one scan code byte asks the text line to do
  typedef struct packed {
    logic [7:0] key;   // decoded character, 0 if none
    logic       bksp;  // backspace make code
  } ps2t_action_t;

  // Key map without Shift; unknown codes give 0
  function automatic logic [7:0] plain_char(input logic [7:0] code);
    logic [7:0] ch;
    unique case (code)
      8'h1C: ch = "a";  8'h32: ch = "b";  8'h21: ch = "c";  8'h23: ch = "d";
      8'h24: ch = "e";  8'h2B: ch = "f";  8'h34: ch = "g";  8'h33: ch = "h";
      8'h43: ch = "i";  8'h3B: ch = "j";  8'h42: ch = "k";  8'h4B: ch = "l";
      8'h3A: ch = "m";  8'h31: ch = "n";  8'h44: ch = "o";  8'h4D: ch = "p";
      8'h15: ch = "q";  8'h2D: ch = "r";  8'h1B: ch = "s";  8'h2C: ch = "t";
      8'h3C: ch = "u";  8'h2A: ch = "v";  8'h1D: ch = "w";  8'h22: ch = "x";
      8'h35: ch = "y";  8'h1A: ch = "z";
      8'h45: ch = "0";  8'h16: ch = "1";  8'h1E: ch = "2";  8'h26: ch = "3";
      8'h25: ch = "4";  8'h2E: ch = "5";  8'h36: ch = "6";  8'h3D: ch = "7";
      8'h3E: ch = "8";  8'h46: ch = "9";
      8'h70: ch = "0";  8'h69: ch = "1";  8'h72: ch = "2";  8'h7A: ch = "3";
      8'h6B: ch = "4";  8'h73: ch = "5";  8'h74: ch = "6";  8'h6C: ch = "7";
      8'h75: ch = "8";  8'h7D: ch = "9";
      8'h4E: ch = "-";  8'h55: ch = "=";  8'h5D: ch = " ";  8'h29: ch = " ";
      8'h54: ch = "[";  8'h5B: ch = "]";  8'h4C: ch = ";";  8'h52: ch = " ";
      8'h41: ch = ",";  8'h49: ch = ".";  8'h4A: ch = "/";  8'h71: ch = ".";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Key map with Shift held; unknown codes give 0
  function automatic logic [7:0] shift_char(input logic [7:0] code);
    logic [7:0] ch;
    unique case (code)
      8'h1C: ch = "A";  8'h32: ch = "B";  8'h21: ch = "C";  8'h23: ch = "D";
      8'h24: ch = "E";  8'h2B: ch = "F";  8'h34: ch = "G";  8'h33: ch = "H";
      8'h43: ch = "I";  8'h3B: ch = "J";  8'h42: ch = "K";  8'h4B: ch = "L";
      8'h3A: ch = "M";  8'h31: ch = "N";  8'h44: ch = "O";  8'h4D: ch = "P";
      8'h15: ch = "Q";  8'h2D: ch = "R";  8'h1B: ch = "S";  8'h2C: ch = "T";
      8'h3C: ch = "U";  8'h2A: ch = "V";  8'h1D: ch = "W";  8'h22: ch = "X";
      8'h35: ch = "Y";  8'h1A: ch = "Z";
      8'h45: ch = ")";  8'h16: ch = "!";  8'h1E: ch = "@";  8'h26: ch = "#";
      8'h25: ch = "$";  8'h2E: ch = "%";  8'h36: ch = "^";  8'h3D: ch = "&";
      8'h3E: ch = "*";  8'h46: ch = "(";
      8'h4E: ch = "_";  8'h55: ch = "+";  8'h5D: ch = "|";  8'h29: ch = " ";
      8'h4C: ch = ":";  8'h41: ch = "<";  8'h49: ch = ">";  8'h4A: ch = "?";
      8'h71: ch = ".";
      8'h70: ch = "0";  8'h69: ch = "1";  8'h72: ch = "2";  8'h7A: ch = "3";
      8'h6B: ch = "4";  8'h73: ch = "5";  8'h74: ch = "6";  8'h6C: ch = "7";
      8'h75: ch = "8";  8'h7D: ch = "9";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

### rtl/core/ps2t_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2t_decode
// Keyboard state (break prefix, Shift) and scan code to character decode.
// ----------------------------------------------------------------------------
module ps2t_decode
  import ps2t_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         take,       // a scan code byte is accepted
  input  wire logic [7:0]   scan_code,
  output ps2t_action_t      action
);

  logic break_pending, break_pending_next;
  logic shift_held, shift_held_next;
  logic is_shift;

  assign is_shift = (scan_code == CODE_LSHIFT) || (scan_code == CODE_RSHIFT);

  // Classify the byte against the current keyboard state
  always_comb begin
    break_pending_next = break_pending;
    shift_held_next    = shift_held;
    action             = '0;
    priority if (break_pending) begin
      // byte after 0xF0 is a release: only Shift matters
      break_pending_next = 1'b0;
      if (is_shift) shift_held_next = 1'b0;
    end else if (scan_code == CODE_BREAK) begin
      break_pending_next = 1'b1;
    end else if (is_shift) begin
      shift_held_next = 1'b1;
    end else if (scan_code == CODE_BKSP) begin
      action.bksp = 1'b1;
    end else begin
      action.key = shift_held ? shift_char(scan_code) : plain_char(scan_code);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      break_pending <= 1'b0;
      shift_held    <= 1'b0;
    end else if (take) begin
      break_pending <= break_pending_next;
      shift_held    <= shift_held_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ps2_scancode_to_text_line.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_scancode_to_text_line
// PS/2 set 2 scan codes to ASCII, kept in a LINE_DEPTH character text line.
// ----------------------------------------------------------------------------
// The block takes one item per clock and returns one result per item, in the
// cycle after acceptance, from a single output register. While a result waits
// for out_ready the input is held off; the cycle the result is taken, the next
// item enters, so items flow back to back with no gap. The text line sits in a
// single-port-write, registered-read memory; the write of one item and the
// read of the next never touch the same cycle, so no forwarding is needed.
// Memory entries at or above the cursor are never cleared; reads there
// return a space instead, so a full-line clear or a reset only moves the
// cursor to zero, with no clearing pass. Backspace moves the cursor back;
// reads of indexes at or beyond LINE_DEPTH return 0.
// ----------------------------------------------------------------------------
module ps2_scancode_to_text_line
  import ps2t_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       func,
  input  wire logic [7:0] scan_code,
  input  wire logic [4:0] read_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      key_char,
  output logic            line_changed,
  output logic            line_cleared,
  output logic [4:0]      cursor_pos,
  output logic [7:0]      read_char
);

  localparam int         AW        = $clog2(LINE_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(LINE_DEPTH - 1);
  localparam logic [8:0] DEPTH_9   = 9'(LINE_DEPTH);

  // Read data source codes
  localparam logic [1:0] RD_ZERO  = 2'd0;
  localparam logic [1:0] RD_BLANK = 2'd1;
  localparam logic [1:0] RD_MEM   = 2'd2;

  logic              accept;
  logic              take_byte;
  ps2t_action_t      action;

  logic [AW-1:0]     cursor, cursor_next;
  logic              changed_next, cleared_next;
  logic              wr_en;
  logic [1:0]        rd_src_next, rd_src;
  logic [7:0]        line_mem [LINE_DEPTH];
  logic [7:0]        mem_q;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign take_byte = accept && !func;

  ps2t_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .take      (take_byte),
    .scan_code (scan_code),
    .action    (action)
  );

  // Cursor update and line write for one byte
  always_comb begin
    cursor_next  = cursor;
    changed_next = 1'b0;
    cleared_next = 1'b0;
    wr_en        = 1'b0;
    if (!func) begin
      if (action.bksp) begin
        if (cursor != '0) begin
          cursor_next  = cursor - 1'b1;
          changed_next = 1'b1;
        end
      end else if (action.key != 8'h00) begin
        changed_next = 1'b1;
        wr_en        = 1'b1;
        if (cursor == LAST_POS) begin
          cursor_next  = '0;
          cleared_next = 1'b1;
        end else begin
          cursor_next = cursor + 1'b1;
        end
      end
    end
  end

  // Where the read character comes from
  always_comb begin
    rd_src_next = RD_ZERO;
    if (func) begin
      if (9'(read_index) < DEPTH_9) begin
        rd_src_next = (9'(read_index) < 9'(cursor)) ? RD_MEM : RD_BLANK;
      end
    end
  end

  // Text line memory
  always_ff @(posedge clk) begin
    if (accept && wr_en) line_mem[cursor] <= action.key;
    if (accept && func)  mem_q <= line_mem[AW'(read_index)];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cursor    <= '0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
        cursor    <= cursor_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_char     <= func ? 8'h00 : action.key;
      line_changed <= changed_next;
      line_cleared <= cleared_next;
      rd_src       <= rd_src_next;
    end
  end

  assign cursor_pos = 5'(cursor);

  always_comb begin
    unique case (rd_src)
      RD_MEM:   read_char = mem_q;
      RD_BLANK: read_char = BLANK;
      default:  read_char = 8'h00;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/ps2t_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2t_checker
// Port-level checks of the text line block, bound to the top level.
// ----------------------------------------------------------------------------
module ps2t_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] key_char,
  input wire logic       line_changed,
  input wire logic       line_cleared,
  input wire logic [4:0] cursor_pos,
  input wire logic [7:0] read_char
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_char) &&
    $stable(cursor_pos) && $stable(read_char))
    else $error("result changed while stalled");

  // A clear is a change, comes from a typed character and homes the cursor
  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_cleared |->
    line_changed && (key_char != 8'h00) && (cursor_pos == 5'd0))
    else $error("bad line clear result");

  // An item is either a byte or a read, never both
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_char == 8'h00) || (read_char == 8'h00))
    else $error("key and read data both set");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind ps2_scancode_to_text_line ps2t_checker u_ps2t_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .key_char     (key_char),
  .line_changed (line_changed),
  .line_cleared (line_cleared),
  .cursor_pos   (cursor_pos),
  .read_char    (read_char)
);
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PS/2 scan code to text line block.
// ----------------------------------------------------------------------------
// A clocked driver feeds scan code bytes and line reads from a queue that the
// stimulus process fills. It starts with a short directed sequence, then runs
// a long mix of realistic keystrokes (make, break prefix, make), Shift
// press/release, backspace runs, reads and random noise bytes. A local model
// of the keyboard state and the text line predicts one result per accepted
// item. A clocked monitor compares every accepted result field by field with
// the oldest prediction. Both sides idle at random, the receiver holds off
// once for a long stretch, and the sender pauses to let the block drain.
// ----------------------------------------------------------------------------
module tb_top;
  import ps2t_pkg::*;

  localparam int LINE_DEPTH = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD = 400;

  // Item kinds
  localparam logic FUNC_KEY = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // A few named scan codes for the directed part
  localparam logic [7:0] SC_A = 8'h1C;
  localparam logic [7:0] SC_1 = 8'h16;
  localparam logic [7:0] SC_MINUS = 8'h4E;
  localparam logic [7:0] SC_LBRACKET = 8'h54;
  localparam logic [7:0] SC_BACKSLASH = 8'h5D;
  localparam logic [7:0] SC_KP9 = 8'h7D;

  // Set 2 key codes, first listed at the top of each vector
  localparam logic [26*8-1:0] ALPHA_CODES = {
    8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B,
    8'h42, 8'h4B, 8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C,
    8'h3C, 8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A};
  localparam logic [10*8-1:0] DIGIT_CODES = {
    8'h45, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46};
  localparam logic [10*8-1:0] DIGIT_SHIFTED = ")!@#$%^&*(";
  localparam logic [10*8-1:0] PAD_CODES = {
    8'h70, 8'h69, 8'h72, 8'h7A, 8'h6B, 8'h73, 8'h74, 8'h6C, 8'h75, 8'h7D};
  localparam logic [12*8-1:0] MISC_CODES = {
    8'h4E, 8'h55, 8'h5D, 8'h29, 8'h54, 8'h5B, 8'h4C, 8'h52, 8'h41, 8'h49,
    8'h4A, 8'h71};

  typedef struct packed {
    logic       func;
    logic [7:0] code;
    logic [4:0] read_index;
  } key_item_t;

  typedef struct packed {
    logic [7:0] key_char;
    logic       line_changed;
    logic       line_cleared;
    logic [4:0] cursor_pos;
    logic [7:0] read_char;
  } line_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       func = FUNC_KEY;
  logic [7:0] scan_code = 8'h00;
  logic [4:0] read_index = 5'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] key_char;
  logic       line_changed;
  logic       line_cleared;
  logic [4:0] cursor_pos;
  logic [7:0] read_char;

  ps2_scancode_to_text_line #(
    .LINE_DEPTH(LINE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .scan_code(scan_code),
    .read_index(read_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .key_char(key_char),
    .line_changed(line_changed),
    .line_cleared(line_cleared),
    .cursor_pos(cursor_pos),
    .read_char(read_char)
  );

  always #5 clk = ~clk;

  key_item_t    typed_items[$];
  line_result_t line_expect[$];
  key_item_t    on_wire;
  int           items_queued = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  // Sender / receiver pacing
  int   tx_gap = 0;
  int   rx_gap = 0;
  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  bit   burst_only = 1'b0;
  bit   want_hold = 1'b0;
  bit   hold_taken = 1'b0;
  int   hold_left = 0;

  // Local keyboard and line state
  logic       brk_seen;
  logic       shift_down;
  int         cur_pos;
  logic [7:0] line_copy [LINE_DEPTH];

  function automatic void blank_line();
    for (int i = 0; i < LINE_DEPTH; i++) line_copy[i] = BLANK;
  endfunction

  // Character for a make code, 0 when the code has no character
  function automatic logic [7:0] char_for(logic [7:0] code, logic shifted);
    logic [15:0] pair;
    for (int i = 0; i < 26; i++)
      if (ALPHA_CODES[8*(25-i) +: 8] == code)
        return (shifted ? 8'h41 : 8'h61) + i[7:0];
    for (int i = 0; i < 10; i++)
      if (DIGIT_CODES[8*(9-i) +: 8] == code)
        return shifted ? DIGIT_SHIFTED[8*(9-i) +: 8] : 8'h30 + i[7:0];
    for (int i = 0; i < 10; i++)
      if (PAD_CODES[8*(9-i) +: 8] == code) return 8'h30 + i[7:0];
    // plain char in the upper byte, shifted char in the lower
    case (code)
      8'h4E:   pair = {"-", "_"};
      8'h55:   pair = {"=", "+"};
      8'h5D:   pair = {" ", "|"};
      8'h29:   pair = {" ", " "};
      8'h54:   pair = {"[", 8'h00};
      8'h5B:   pair = {"]", 8'h00};
      8'h4C:   pair = {";", ":"};
      8'h52:   pair = {" ", 8'h00};
      8'h41:   pair = {",", "<"};
      8'h49:   pair = {".", ">"};
      8'h4A:   pair = {"/", "?"};
      8'h71:   pair = {".", "."};
      default: pair = 16'h0000;
    endcase
    return shifted ? pair[7:0] : pair[15:8];
  endfunction

  // Apply one accepted item to the local state and return its result
  function automatic line_result_t type_into_line(key_item_t it);
    line_result_t r;
    logic [7:0]   ch;
    r = '0;
    if (it.func == FUNC_READ) begin
      if (int'(it.read_index) < LINE_DEPTH) r.read_char = line_copy[it.read_index];
    end else if (brk_seen) begin
      // byte after the break prefix only releases Shift
      brk_seen = 1'b0;
      if (it.code == CODE_LSHIFT || it.code == CODE_RSHIFT) shift_down = 1'b0;
    end else if (it.code == CODE_BREAK) begin
      brk_seen = 1'b1;
    end else if (it.code == CODE_LSHIFT || it.code == CODE_RSHIFT) begin
      shift_down = 1'b1;
    end else if (it.code == CODE_BKSP) begin
      if (cur_pos > 0) begin
        cur_pos--;
        line_copy[cur_pos] = BLANK;
        r.line_changed = 1'b1;
      end
    end else begin
      ch = char_for(it.code, shift_down);
      r.key_char = ch;
      if (ch != 8'h00) begin
        r.line_changed = 1'b1;
        line_copy[cur_pos] = ch;
        cur_pos++;
        // full line: wipe it and home the cursor
        if (cur_pos >= LINE_DEPTH) begin
          blank_line();
          cur_pos = 0;
          r.line_cleared = 1'b1;
        end
      end
    end
    r.cursor_pos = cur_pos[4:0];
    return r;
  endfunction

  // Mostly short idles, some medium, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] any_key_code();
    int k;
    k = $urandom_range(0, 57);
    if (k < 26) return ALPHA_CODES[8*(25-k) +: 8];
    if (k < 36) return DIGIT_CODES[8*(35-k) +: 8];
    if (k < 46) return PAD_CODES[8*(45-k) +: 8];
    return MISC_CODES[8*(57-k) +: 8];
  endfunction

  task automatic push_byte(logic [7:0] code);
    key_item_t it;
    it.func = FUNC_KEY;
    it.code = code;
    it.read_index = 5'($urandom_range(0, 31));
    typed_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_read(logic [4:0] idx);
    key_item_t it;
    it.func = FUNC_READ;
    it.code = 8'($urandom_range(0, 255));
    it.read_index = idx;
    typed_items.push_back(it);
    items_queued++;
  endtask

  // A full keystroke: make, break prefix, make
  task automatic strike(logic [7:0] code);
    push_byte(code);
    push_byte(CODE_BREAK);
    push_byte(code);
  endtask

  task automatic add_random_action();
    int         r;
    logic [7:0] code;
    logic [7:0] sh;
    r = $urandom_range(0, 99);
    code = any_key_code();
    sh = $urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT;
    if (r < 45) begin
      strike(code);
    end else if (r < 55) begin
      // shifted word; sometimes released with the other Shift key
      push_byte(sh);
      repeat ($urandom_range(1, 4)) strike(any_key_code());
      push_byte(CODE_BREAK);
      if ($urandom_range(0, 3) == 0)
        push_byte(sh == CODE_LSHIFT ? CODE_RSHIFT : CODE_LSHIFT);
      else
        push_byte(sh);
    end else if (r < 63) begin
      strike(CODE_BKSP);
    end else if (r < 75) begin
      push_read(5'($urandom_range(0, 31)));
    end else if (r < 83) begin
      push_byte(8'($urandom_range(0, 255)));
    end else if (r < 90) begin
      // typematic repeat of a held key
      repeat ($urandom_range(2, 4)) push_byte(code);
    end else if (r < 95) begin
      push_byte(CODE_BREAK);
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) push_byte(CODE_BKSP);
    end
  endtask

  task automatic wait_drained();
    while (typed_items.size() != 0 || in_valid || line_expect.size() != 0)
      @(negedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: one item on the wire, next one popped once it is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) line_expect.push_back(type_into_line(on_wire));
      if ($urandom_range(0, 299) == 0) tx_steady = !tx_steady;
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (typed_items.size() != 0) begin
          on_wire = typed_items.pop_front();
          func <= on_wire.func;
          scan_code <= on_wire.code;
          read_index <= on_wire.read_index;
          in_valid <= 1'b1;
          tx_gap = (burst_only || tx_steady) ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result, then pace out_ready
  always @(posedge clk) begin
    line_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (line_expect.size() == 0) begin
          $error("result with no item outstanding");
          mismatches++;
        end else begin
          want = line_expect.pop_front();
          check_field("key_char", want.key_char, key_char);
          check_field("line_changed", 8'(want.line_changed), 8'(line_changed));
          check_field("line_cleared", 8'(want.line_cleared), 8'(line_cleared));
          check_field("cursor_pos", 8'(want.cursor_pos), 8'(cursor_pos));
          check_field("read_char", want.read_char, read_char);
        end
      end
      if ($urandom_range(0, 299) == 0) rx_steady = !rx_steady;
      if (want_hold && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) rx_gap = idle_len();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ps2_scancode_to_text_line verification failed");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    brk_seen = 1'b0;
    shift_down = 1'b0;
    cur_pos = 0;
    blank_line();

    // Directed: reads at both ends, odd bytes, Shift, break prefix twice
    push_read(5'd0);
    push_read(5'd31);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CODE_BKSP);          // backspace with the cursor home
    push_byte(SC_A);
    push_byte(CODE_BKSP);
    push_byte(CODE_LSHIFT);
    push_byte(SC_A);
    push_byte(SC_LBRACKET);        // no shifted character
    push_byte(SC_1);
    push_byte(CODE_BREAK);
    push_byte(CODE_LSHIFT);
    push_byte(CODE_RSHIFT);
    push_byte(SC_MINUS);
    push_byte(CODE_BREAK);
    push_byte(CODE_BREAK);         // break prefix eaten as a break code
    push_byte(CODE_BREAK);
    push_byte(CODE_RSHIFT);
    push_byte(SC_KP9);
    push_byte(SC_BACKSLASH);
    push_read(5'd1);
    push_read(5'd2);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // Back-to-back typing into a receiver that stops for a long while
    burst_only = 1'b1;
    want_hold = 1'b1;
    repeat (80) push_byte(any_key_code());
    wait_drained();
    burst_only = 1'b0;

    // Random keyboard traffic, with a full drain in the middle
    items_queued = 0;
    while (items_queued < 850) add_random_action();
    wait_drained();
    while (items_queued < 1700) add_random_action();
    wait_drained();

    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("ps2_scancode_to_text_line verification clean");
    end else begin
      $display("ps2_scancode_to_text_line verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/ps2t_pkg.sv
rtl/core/ps2t_decode.sv
rtl/core/ps2_scancode_to_text_line.sv
rtl/core/ps2t_checker.sv
tb/tb_top.sv
